// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

    // Sizes of the page map
    localparam int MAX_PAGES = 4096;
    localparam int MAP_BYTES = MAX_PAGES / 8;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int BIT_W     = 3;
    localparam int PAGE_W    = ADDR_W + BIT_W;
    localparam int CNT_W     = PAGE_W + 1;
    localparam int ACC_W     = 32;

    // Stream widths
    localparam int IN_DATA_W  = ((PAGE_W + 7) / 8) * 8;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int OUT_BITS   = PAGE_W + STAT_W + 3 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = CNT_W'(MAX_PAGES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOCK,
        OP_UNRESERVE
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_SAME,
        STAT_RANGE,
        STAT_NOFREE
    } t_status;

endpackage

`default_nettype wire

// File: rtl/bitmap_page_frame_allocator_core.sv
`default_nettype none

// Channel    Direction  Handshake                  Contents
// s (input)  in         i_s_tvalid / o_s_tready    tuser: opcode; tdata: page_index
// m (result) out        o_m_tvalid / i_m_tready    tdata: page, status, free, used, reserved
// cfg        in         i_cfg_valid / o_cfg_ready  page_count (always ready)
//
// Free, lock and unreserve go in order: the map byte is read as the request is
// accepted, then evaluated and written back, then the result register is loaded
// once it is free. An allocate examines one map byte per cycle from the hint
// until it finds a free page inside the bound or ends with no free page at the
// bound's last byte. Out-of-range results, and no-free-page results with the
// hint already at the bound, skip the map and go straight to the result.
// After reset all 512 map bytes are swept to zero, one byte a cycle, before the first
// transaction. A stalled result waits in its register; the next item is taken meanwhile.

module bitmap_page_frame_allocator_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // page_index [11:0], zero [15:12]
    input  wire  [bpfa_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // opcode [1:0]
    input  wire  [bpfa_pkg::OP_W-1:0]           i_s_tuser,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // result_page [11:0], status [13:12], free_pages [26:14],
    // used_pages [39:27], reserved_pages [52:40], zero [55:53]
    output logic [bpfa_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire  [bpfa_pkg::CNT_W-1:0]          i_cfg_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready
);

    localparam int PW = bpfa_pkg::PAGE_W;
    localparam int CW = bpfa_pkg::CNT_W;
    localparam int AW = bpfa_pkg::ADDR_W;
    localparam int BW = bpfa_pkg::BIT_W;
    localparam int KW = bpfa_pkg::ACC_W;

    // Control state
    bpfa_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [PW-1:0]     r_hint, n_hint;
    logic [CW-1:0]     r_marked, n_marked;
    logic [KW-1:0]     r_used, n_used;
    logic [KW-1:0]     r_rsvd, n_rsvd;
    logic [CW-1:0]     r_page_count;
    logic              r_out_valid, n_out_valid;

    // Payload
    bpfa_pkg::t_op     r_op, n_op;
    logic [PW-1:0]     r_idx, n_idx;
    logic              r_first, n_first;
    logic [PW-1:0]     r_res_page, n_res_page;
    bpfa_pkg::t_status r_res_status, n_res_status;
    logic [bpfa_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Page map
    logic [7:0]        r_map [bpfa_pkg::MAP_BYTES];
    logic [7:0]        r_rdata;
    logic              w_mem_we;
    logic [7:0]        w_mem_wdata;

    // Derived values
    logic [CW-1:0]     w_lim;
    logic [PW-1:0]     w_last_page;
    logic [7:0]        w_cand;
    logic [BW-1:0]     w_sel;
    logic [7:0]        w_sel_mask;
    logic [7:0]        w_idx_mask;
    logic              w_idx_set;
    logic [CW-1:0]     w_free;

    assign o_s_tready  = (r_state == bpfa_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Effective bound, page_count saturated to the map size
    always_comb begin
        if (r_page_count > CW'(bpfa_pkg::MAX_PAGES)) begin
            w_lim = CW'(bpfa_pkg::MAX_PAGES);
        end else begin
            w_lim = r_page_count;
        end
        w_last_page = PW'(w_lim - CW'(1));
        w_free      = (w_lim > r_marked) ? (w_lim - r_marked) : '0;
    end

    // First-fit search inside the current byte; page 8k+j sits at bit 7-j
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_cand[j] = !r_rdata[7-j]
                        && (!r_first || (BW'(j) >= r_hint[BW-1:0]))
                        && ((r_addr != w_last_page[PW-1:BW])
                            || (BW'(j) <= w_last_page[BW-1:0]));
        end
        w_sel = '0;
        for (int j = 7; j >= 0; j--) begin
            if (w_cand[j]) begin
                w_sel = BW'(j);
            end
        end
        w_sel_mask = 8'h80 >> w_sel;
        w_idx_mask = 8'h80 >> r_idx[BW-1:0];
        w_idx_set  = |(r_rdata & w_idx_mask);
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_hint       = r_hint;
        n_marked     = r_marked;
        n_used       = r_used;
        n_rsvd       = r_rsvd;
        n_op         = r_op;
        n_idx        = r_idx;
        n_first      = r_first;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && !i_m_tready;
        w_mem_we     = 1'b0;
        w_mem_wdata  = r_rdata;

        unique case (r_state)
            bpfa_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = '0;
                n_addr      = r_addr + AW'(1);
                if (r_addr == AW'(bpfa_pkg::MAP_BYTES - 1)) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end

            bpfa_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_op         = bpfa_pkg::t_op'(i_s_tuser);
                    n_idx        = i_s_tdata[PW-1:0];
                    n_res_page   = i_s_tdata[PW-1:0];
                    n_res_status = bpfa_pkg::STAT_OK;
                    n_first      = 1'b1;
                    if (bpfa_pkg::t_op'(i_s_tuser) == bpfa_pkg::OP_ALLOC) begin
                        if ({1'b0, r_hint} >= w_lim) begin
                            n_res_page   = '0;
                            n_res_status = bpfa_pkg::STAT_NOFREE;
                            n_state      = bpfa_pkg::ST_DONE;
                        end else begin
                            n_addr  = r_hint[PW-1:BW];
                            n_state = bpfa_pkg::ST_EVAL;
                        end
                    end else if ({1'b0, i_s_tdata[PW-1:0]} >= w_lim) begin
                        n_res_status = bpfa_pkg::STAT_RANGE;
                        n_state      = bpfa_pkg::ST_DONE;
                    end else begin
                        n_addr  = i_s_tdata[PW-1:BW];
                        n_state = bpfa_pkg::ST_EVAL;
                    end
                end
            end

            bpfa_pkg::ST_EVAL: begin
                unique case (r_op)
                    bpfa_pkg::OP_ALLOC: begin
                        if (|w_cand) begin
                            w_mem_we     = 1'b1;
                            w_mem_wdata  = r_rdata | w_sel_mask;
                            n_marked     = r_marked + CW'(1);
                            n_used       = r_used + KW'(1);
                            n_hint       = {r_addr, w_sel};
                            n_res_page   = {r_addr, w_sel};
                            n_res_status = bpfa_pkg::STAT_OK;
                            n_state      = bpfa_pkg::ST_DONE;
                        end else if (r_addr == w_last_page[PW-1:BW]) begin
                            n_res_page   = '0;
                            n_res_status = bpfa_pkg::STAT_NOFREE;
                            n_state      = bpfa_pkg::ST_DONE;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_first = 1'b0;
                        end
                    end
                    bpfa_pkg::OP_LOCK: begin
                        n_state = bpfa_pkg::ST_DONE;
                        if (w_idx_set) begin
                            n_res_status = bpfa_pkg::STAT_SAME;
                        end else begin
                            w_mem_we    = 1'b1;
                            w_mem_wdata = r_rdata | w_idx_mask;
                            n_marked    = r_marked + CW'(1);
                            n_rsvd      = r_rsvd + KW'(1);
                        end
                    end
                    bpfa_pkg::OP_FREE, bpfa_pkg::OP_UNRESERVE: begin
                        n_state = bpfa_pkg::ST_DONE;
                        if (!w_idx_set) begin
                            n_res_status = bpfa_pkg::STAT_SAME;
                        end else begin
                            w_mem_we    = 1'b1;
                            w_mem_wdata = r_rdata & ~w_idx_mask;
                            if (r_marked != '0) begin
                                n_marked = r_marked - CW'(1);
                            end
                            if (r_op == bpfa_pkg::OP_FREE) begin
                                if (r_used != '0) begin
                                    n_used = r_used - KW'(1);
                                end
                            end else if (r_rsvd != '0) begin
                                n_rsvd = r_rsvd - KW'(1);
                            end
                            if (r_hint > r_idx) begin
                                n_hint = r_idx;
                            end
                        end
                    end
                    default: begin
                        n_state = bpfa_pkg::ST_DONE;
                    end
                endcase
            end

            bpfa_pkg::ST_DONE: begin
                // Load the result once the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_data  = bpfa_pkg::OUT_DATA_W'({r_rsvd[CW-1:0], r_used[CW-1:0],
                                                         w_free, r_res_status, r_res_page});
                    n_out_valid = 1'b1;
                    n_state     = bpfa_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpfa_pkg::ST_CLEAR;
            r_addr       <= '0;
            r_hint       <= '0;
            r_marked     <= '0;
            r_used       <= '0;
            r_rsvd       <= '0;
            r_out_valid  <= 1'b0;
            r_page_count <= bpfa_pkg::PAGE_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_hint      <= n_hint;
            r_marked    <= n_marked;
            r_used      <= n_used;
            r_rsvd      <= n_rsvd;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_page_count <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_first      <= n_first;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

    // Page map: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_map[r_addr] <= w_mem_wdata;
        end
        r_rdata <= r_map[n_addr];
    end

endmodule

`default_nettype wire

// File: rtl/bpfa_checker.sv
`default_nettype none

`include "assert_macros.svh"

module bpfa_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_s_tvalid,
    input wire                                o_s_tready,
    input wire [bpfa_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input wire                                o_m_tvalid,
    input wire                                i_m_tready
);

    // Map clearing pass keeps the input side closed right after reset
    `ASSERT_CLK_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !o_s_tready, "ready after reset")

    // One item at a time: the input closes once a transaction is accepted
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "ready right after accept")

    // A stalled result holds its payload
    `ASSERT_CLK(a_hold_stalled, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata), "stalled result changed")

    // No free page reports page zero
    `ASSERT_CLK(a_nofree_page0, i_clk, i_rst_n, (o_m_tvalid && (o_m_tdata[13:12] == bpfa_pkg::STAT_NOFREE)) |-> (o_m_tdata[11:0] == '0), "nonzero page on no-free status")

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire

// File: tb/bitmap_page_frame_allocator_core_tb.sv
`default_nettype none

module bitmap_page_frame_allocator_core_tb;

    localparam int PW  = bpfa_pkg::PAGE_W;
    localparam int CW  = bpfa_pkg::CNT_W;
    localparam int IW  = bpfa_pkg::IN_DATA_W;
    localparam int OW  = bpfa_pkg::OUT_DATA_W;
    localparam int MXP = bpfa_pkg::MAX_PAGES;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    // One result transaction, unpacked
    typedef struct {
        logic [PW-1:0]     page;
        bpfa_pkg::t_status status;
        logic [CW-1:0]     free_p;
        logic [CW-1:0]     used_p;
        logic [CW-1:0]     resv_p;
    } t_alloc_reply;

    // Tracks the page map and counters, predicts each reply, checks replies in order
    class page_alloc_scoreboard;
        logic [7:0]       map_bytes [bpfa_pkg::MAP_BYTES];
        logic [CW-1:0]    hint;
        logic [CW-1:0]    marked;
        int unsigned      used;
        int unsigned      reserved;
        logic [CW-1:0]    page_count;
        t_alloc_reply     pending_replies [$];
        int               errors;

        function new();
            foreach (map_bytes[k]) map_bytes[k] = 8'h00;
            hint = '0;
            marked = '0;
            used = 0;
            reserved = 0;
            page_count = bpfa_pkg::PAGE_COUNT_RST;
            errors = 0;
        endfunction

        // MSB of each byte is the lowest page of that byte
        function bit is_marked(int p);
            return (map_bytes[p >> 3] & (8'h80 >> (p & 7))) != 8'h00;
        endfunction

        function void mark(int p, bit v);
            if (v) map_bytes[p >> 3] = map_bytes[p >> 3] | (8'h80 >> (p & 7));
            else   map_bytes[p >> 3] = map_bytes[p >> 3] & ~(8'h80 >> (p & 7));
        endfunction

        function logic [CW-1:0] bound();
            return (page_count > CW'(MXP)) ? CW'(MXP) : page_count;
        endfunction

        // First marked page at or after start, wrapping inside the bound
        function int nearest_marked(int start);
            int lim;
            int p;
            lim = bound();
            for (int q = 0; q < lim; q++) begin
                p = (start + q) % lim;
                if (is_marked(p)) return p;
            end
            return start;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Apply one accepted request to the model and queue its reply
        function void note_request(bpfa_pkg::t_op op, logic [PW-1:0] idx);
            t_alloc_reply r;
            logic [CW-1:0] lim;
            lim = bound();
            r.page = idx;
            r.status = bpfa_pkg::STAT_OK;
            if (op == bpfa_pkg::OP_ALLOC) begin
                r.status = bpfa_pkg::STAT_NOFREE;
                r.page = '0;
                for (int q = hint; q < lim; q++) begin
                    if (!is_marked(q)) begin
                        mark(q, 1'b1);
                        marked++;
                        used++;
                        hint = CW'(q);
                        r.page = PW'(q);
                        r.status = bpfa_pkg::STAT_OK;
                        break;
                    end
                end
            end else if ({1'b0, idx} >= lim) begin
                r.status = bpfa_pkg::STAT_RANGE;
            end else if (op == bpfa_pkg::OP_LOCK) begin
                if (is_marked(idx)) begin
                    r.status = bpfa_pkg::STAT_SAME;
                end else begin
                    mark(idx, 1'b1);
                    marked++;
                    reserved++;
                end
            end else begin
                if (!is_marked(idx)) begin
                    r.status = bpfa_pkg::STAT_SAME;
                end else begin
                    mark(idx, 1'b0);
                    if (marked != 0) marked--;
                    if (op == bpfa_pkg::OP_FREE) begin
                        if (used != 0) used--;
                    end else begin
                        if (reserved != 0) reserved--;
                    end
                    if (hint > {1'b0, idx}) hint = {1'b0, idx};
                end
            end
            r.free_p = (lim > marked) ? lim - marked : '0;
            r.used_p = CW'(used);
            r.resv_p = CW'(reserved);
            pending_replies.push_back(r);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_reply(logic [OW-1:0] data);
            t_alloc_reply r;
            if (pending_replies.size() == 0) begin
                $error("unexpected result transaction: tdata %h", data);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            if (data[11:0] !== r.page) begin
                $error("result_page: expected %0d, actual %0d", r.page, data[11:0]);
                errors++;
            end
            if (data[13:12] !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, data[13:12]);
                errors++;
            end
            if (data[26:14] !== r.free_p) begin
                $error("free_pages: expected %0d, actual %0d", r.free_p, data[26:14]);
                errors++;
            end
            if (data[39:27] !== r.used_p) begin
                $error("used_pages: expected %0d, actual %0d", r.used_p, data[39:27]);
                errors++;
            end
            if (data[52:40] !== r.resv_p) begin
                $error("reserved_pages: expected %0d, actual %0d", r.resv_p, data[52:40]);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic [IW-1:0]              i_s_tdata = '0;
    logic [bpfa_pkg::OP_W-1:0]  i_s_tuser = '0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [OW-1:0]              o_m_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [CW-1:0]              i_cfg_data = '0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;

    page_alloc_scoreboard sb = new();

    // Shared with the receiver; written only right after a rising edge
    bit calm = 1'b0;
    int hold_trigger = 0;

    bitmap_page_frame_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    always #4 i_clk = ~i_clk;

    // Receiver back-pressure: random stalls, plus one long hold on request
    int seen_trigger = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_trigger != seen_trigger) begin
            seen_trigger = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_reply(o_m_tdata);
    end

    // Offer one request; returns at the falling edge after its transaction
    task automatic send_request(bpfa_pkg::t_op op, logic [PW-1:0] idx);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 31) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {{(IW-PW){1'b0}}, idx};
        i_s_tuser = op;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, idx);
        @(negedge i_clk);
    endtask

    // Wait out every reply, then let the block settle
    task automatic drain();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_page_count(logic [CW-1:0] v);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.page_count = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_calm(bit v);
        @(posedge i_clk);
        calm = v;
        @(negedge i_clk);
    endtask

    task automatic request_hold();
        @(posedge i_clk);
        hold_trigger++;
        @(negedge i_clk);
    endtask

    // Mostly allocations and frees aimed at marked pages, plus some noise
    task automatic random_request();
        int lim;
        int r;
        int top;
        bpfa_pkg::t_op op;
        logic [PW-1:0] idx;
        lim = sb.bound();
        r = $urandom_range(0, 99);
        if (r < 40)      op = bpfa_pkg::OP_ALLOC;
        else if (r < 65) op = bpfa_pkg::OP_FREE;
        else if (r < 80) op = bpfa_pkg::OP_LOCK;
        else             op = bpfa_pkg::OP_UNRESERVE;
        top = lim + lim / 8 + 1;
        if (top > MXP - 1) top = MXP - 1;
        if ((op == bpfa_pkg::OP_FREE || op == bpfa_pkg::OP_UNRESERVE)
            && $urandom_range(0, 1) == 1)
            idx = PW'(sb.nearest_marked($urandom_range(0, lim - 1)));
        else if ($urandom_range(0, 4) == 0)
            idx = PW'($urandom);
        else
            idx = PW'($urandom_range(0, top));
        send_request(op, idx);
    endtask

    int phase_count [10] = '{16, 4096, 37, 1, 8191, 200, 4096, 64, 2, 3000};

    initial begin
        // Reset, then wait for the map sweep to finish
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);

        // Directed: full bound, every op, repeats, reserved page paths
        write_page_count(bpfa_pkg::PAGE_COUNT_RST);
        send_request(bpfa_pkg::OP_ALLOC, 12'hABC);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        send_request(bpfa_pkg::OP_LOCK, 12'hFFF);
        send_request(bpfa_pkg::OP_LOCK, 12'hFFF);
        send_request(bpfa_pkg::OP_LOCK, 12'h002);
        send_request(bpfa_pkg::OP_ALLOC, 12'h555);
        send_request(bpfa_pkg::OP_FREE, 12'h000);
        send_request(bpfa_pkg::OP_FREE, 12'h000);
        send_request(bpfa_pkg::OP_UNRESERVE, 12'h002);
        send_request(bpfa_pkg::OP_UNRESERVE, 12'h001);
        send_request(bpfa_pkg::OP_UNRESERVE, 12'h001);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        drain();

        // Directed: tiny bound with a page marked past it, exhaustion, range
        write_page_count(13'd4);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        send_request(bpfa_pkg::OP_ALLOC, 12'hFFF);
        send_request(bpfa_pkg::OP_FREE, 12'h004);
        send_request(bpfa_pkg::OP_LOCK, 12'hFFF);
        send_request(bpfa_pkg::OP_UNRESERVE, 12'hFFF);
        drain();

        // Directed: single page, then the widest register value
        write_page_count(13'd1);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        send_request(bpfa_pkg::OP_FREE, 12'h000);
        send_request(bpfa_pkg::OP_ALLOC, 12'h000);
        drain();
        write_page_count(13'h1FFF);
        send_request(bpfa_pkg::OP_FREE, 12'hFFF);
        send_request(bpfa_pkg::OP_UNRESERVE, 12'h003);
        drain();

        // Random phases over several bounds
        foreach (phase_count[ph]) begin
            write_page_count(CW'(phase_count[ph]));
            if (ph == 5) set_calm(1'b1);
            for (int n = 0; n < 115; n++) begin
                if (ph == 1 && n == 20) request_hold();
                random_request();
            end
            drain();
            if (ph == 5) set_calm(1'b0);
        end

        if (sb.errors == 0) begin
            $display("bitmap_page_frame_allocator_core_tb: done, clean");
        end else begin
            $display("bitmap_page_frame_allocator_core_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #24000000;
        $display("bitmap_page_frame_allocator_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
